FILE: rtl/core/dense_graph_shortest_paths_assert.svh
// Assertion macros shared by the shortest-path RTL.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef DENSE_GRAPH_SHORTEST_PATHS_ASSERT_SVH
`define DENSE_GRAPH_SHORTEST_PATHS_ASSERT_SVH

// same-cycle implication
`define DGSP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define DGSP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/dgsp_pkg.sv
// Shared types and constants for the shortest-path block.
// No dependencies.
`default_nettype none

package dgsp_pkg;

  // VID_W and DIST_W sized for up to 16 vertices; the port fields for up to 4
  localparam int VID_W      = 4;
  localparam int WEIGHT_W   = 16;
  localparam int DIST_W     = 20;
  localparam int FLD_VID_W  = 2;
  localparam int OUT_DIST_W = 18;
  localparam int SRC_W      = 2;
  localparam int CFG_AW     = 3;

  // register index codes
  localparam logic CFG_IDX_SOURCE = 1'b0;

  // min-search request walking down the chain
  typedef struct packed {
    logic              valid;
    logic              have;
    logic              known;
    logic [DIST_W-1:0] distance;
    logic [VID_W-1:0]  idx;
  } pick_tok_t;

  // one matrix-row entry walking down the chain
  typedef struct packed {
    logic                valid;
    logic                en;
    logic [VID_W-1:0]    col;
    logic [WEIGHT_W-1:0] w;
    logic [DIST_W-1:0]   du;
  } relax_tok_t;

  typedef struct packed {
    logic             init;
    logic             settle;
    logic [VID_W-1:0] settle_idx;
  } cell_ctl_t;

  typedef struct packed {
    logic              known;
    logic              settled;
    logic [DIST_W-1:0] distance;
  } cell_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/dgsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dgsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire                       clk,
  input  wire                       wr_en,
  input  wire  [$clog2(DEPTH)-1:0]  wr_addr,
  input  wire  [WIDTH-1:0]          wr_data,
  input  wire                       rd_en,
  input  wire  [$clog2(DEPTH)-1:0]  rd_addr,
  output logic [WIDTH-1:0]          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/dgsp_cell.sv
// One vertex cell: holds distance, known and settled flags; takes part in the
// min-search and relaxation requests that pass down the chain. Uses dgsp_pkg.
`default_nettype none

module dgsp_cell
  import dgsp_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire         clk,
  input  wire         rst_n,
  input  cell_ctl_t   ctl,
  input  wire         is_source,
  input  pick_tok_t   pick_in,
  output pick_tok_t   pick_out,
  input  relax_tok_t  relax_in,
  output relax_tok_t  relax_out,
  output cell_stat_t  stat
);

  localparam logic [VID_W-1:0] MY_IDX = VID_W'(IDX);

  logic              known_r, known_nxt;
  logic              settled_r, settled_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  pick_tok_t         pick_r, pick_nxt;
  relax_tok_t        relax_r;

  logic              take;
  logic              hit;
  logic [DIST_W-1:0] cand;

  // later index wins ties since the request visits cells in ascending order
  always_comb begin
    if (settled_r) begin
      take = 1'b0;
    end else if (!pick_in.have) begin
      take = 1'b1;
    end else if (!known_r) begin
      take = !pick_in.known;
    end else begin
      take = !pick_in.known || (dist_r <= pick_in.distance);
    end

    pick_nxt = pick_in;
    if (pick_in.valid && take) begin
      pick_nxt.have     = 1'b1;
      pick_nxt.known    = known_r;
      pick_nxt.distance = dist_r;
      pick_nxt.idx      = MY_IDX;
    end
  end

  always_comb begin
    cand = relax_in.du + DIST_W'(relax_in.w);
    hit  = relax_in.valid && relax_in.en && (relax_in.col == MY_IDX) && !settled_r &&
           (relax_in.w != '0);

    known_nxt   = known_r;
    settled_nxt = settled_r;
    dist_nxt    = dist_r;
    if (ctl.init) begin
      known_nxt   = is_source;
      settled_nxt = 1'b0;
      dist_nxt    = '0;
    end else begin
      if (ctl.settle && (ctl.settle_idx == MY_IDX)) begin
        settled_nxt = 1'b1;
      end
      if (hit && (!known_r || (cand < dist_r))) begin
        known_nxt = 1'b1;
        dist_nxt  = cand;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      known_r   <= 1'b0;
      settled_r <= 1'b0;
      pick_r    <= '0;
      relax_r   <= '0;
    end else begin
      known_r   <= known_nxt;
      settled_r <= settled_nxt;
      pick_r    <= pick_nxt;
      relax_r   <= relax_in;
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
  end

  assign pick_out       = pick_r;
  assign relax_out      = relax_r;
  assign stat.known     = known_r;
  assign stat.settled   = settled_r;
  assign stat.distance  = dist_r;

endmodule

`default_nettype wire

FILE: rtl/core/dense_graph_shortest_paths.sv
// Dense-graph shortest paths: matrix load, then a row of vertex cells.
// Load: one matrix entry per cycle while in_tready is high. After the last entry, V-1
// rounds (each: a min-search walks the V cells, then a matrix row walks the chain),
// a drain until the last row entry leaves the chain, then V results at one per
// cycle while out_tready is high. Reset: sync, active low; a clearing pass then zeroes
// the V*V weight RAM, in_tready low. Uses dgsp_pkg, dgsp_cell, dgsp_ram.
`default_nettype none
`include "dense_graph_shortest_paths_assert.svh"

module dense_graph_shortest_paths
  import dgsp_pkg::*;
#(
  parameter int VERTEX_COUNT = 4
) (
  input  wire                clk,
  input  wire                rst_n,
  // input requests
  input  wire                in_tvalid,
  output logic               in_tready,
  input  wire  [23:0]        in_tdata,   // from_vertex[1:0], to_vertex[3:2], edge_weight[19:4]
  input  wire                in_tlast,   // last_entry
  // results
  output logic               out_tvalid,
  input  wire                out_tready,
  output logic [23:0]        out_tdata,  // vertex_index[1:0], path_distance[19:2]
  output logic               out_tuser,  // reachable
  output logic               out_tlast,  // last_result
  // configuration
  input  wire                cfg_psel,
  input  wire                cfg_penable,
  input  wire                cfg_pwrite,
  input  wire  [CFG_AW-1:0]  cfg_paddr,
  input  wire  [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int DEPTH = VERTEX_COUNT * VERTEX_COUNT;
  localparam int AW    = $clog2(DEPTH);
  localparam int VW    = $clog2(VERTEX_COUNT);
  localparam logic [VW-1:0] LAST_V     = VW'(VERTEX_COUNT - 1);
  localparam logic [VW-1:0] LAST_ROUND = VW'(VERTEX_COUNT - 2);
  localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_PICK, ST_RELAX, ST_DRAIN, ST_OUT
  } state_t;

  state_t              state_r;
  logic [SRC_W-1:0]    cfg_source_r;
  logic [AW-1:0]       clr_addr_r;
  logic [VW-1:0]       round_r;
  logic [VW-1:0]       col_r;
  logic [VW-1:0]       rd_col_r;
  logic                rd_pend_r;
  logic                pick_sent_r;
  logic [VID_W-1:0]    u_r;
  logic                u_known_r;
  logic [DIST_W-1:0]   du_r;
  logic [VW-1:0]       out_idx_r;
  logic                out_tvalid_r;
  logic [FLD_VID_W-1:0]  out_vid_r;
  logic [OUT_DIST_W-1:0] out_dist_r;
  logic                out_reach_r;
  logic                out_last_r;

  // input fields
  logic [FLD_VID_W-1:0] in_from;
  logic [FLD_VID_W-1:0] in_to;
  logic [WEIGHT_W-1:0]  in_weight;
  logic                 in_accept;
  logic                 in_range;
  logic [31:0]          wr_addr_full;
  logic [31:0]          rd_addr_full;

  // RAM
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [WEIGHT_W-1:0] ram_wdata;
  logic                ram_re;
  logic [WEIGHT_W-1:0] ram_rdata;

  // chain
  cell_ctl_t   ctl;
  pick_tok_t   pick_chain  [VERTEX_COUNT+1];
  relax_tok_t  relax_chain [VERTEX_COUNT+1];
  cell_stat_t  stat_vec    [VERTEX_COUNT];
  logic [VERTEX_COUNT-1:0] settled_vec;
  logic        pick_inject;
  pick_tok_t   pick_exit;
  relax_tok_t  relax_exit;

  // output
  cell_stat_t          sel_stat;
  logic                out_load;
  logic [VW+1:0]       out_idx_ext;
  logic [DIST_W+OUT_DIST_W-1:0] dist_ext;

  // config
  logic cfg_wr;

  assign in_from   = in_tdata[1:0];
  assign in_to     = in_tdata[3:2];
  assign in_weight = in_tdata[19:4];
  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign in_range  = ({30'b0, in_from} < 32'(VERTEX_COUNT)) &&
                     ({30'b0, in_to} < 32'(VERTEX_COUNT));

  assign wr_addr_full = 32'(in_from) * 32'(VERTEX_COUNT) + 32'(in_to);
  assign rd_addr_full = 32'(u_r) * 32'(VERTEX_COUNT) + 32'(col_r);

  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = in_accept && in_range;
      ram_waddr = wr_addr_full[AW-1:0];
      ram_wdata = in_weight;
    end
  end

  assign ram_re = (state_r == ST_RELAX);

  dgsp_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (DEPTH)
  ) u_weights (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (rd_addr_full[AW-1:0]),
    .rd_data (ram_rdata)
  );

  // the min-search waits until the last row entry has entered the chain so it trails it
  assign pick_inject = (state_r == ST_PICK) && !pick_sent_r && !rd_pend_r;

  always_comb begin
    pick_chain[0]       = '0;
    pick_chain[0].valid = pick_inject;

    relax_chain[0].valid = rd_pend_r;
    relax_chain[0].en    = u_known_r;
    relax_chain[0].col   = VID_W'(rd_col_r);
    relax_chain[0].w     = ram_rdata;
    relax_chain[0].du    = du_r;
  end

  assign pick_exit  = pick_chain[VERTEX_COUNT];
  assign relax_exit = relax_chain[VERTEX_COUNT];

  assign ctl.init       = in_accept && in_tlast;
  assign ctl.settle     = (state_r == ST_PICK) && pick_exit.valid;
  assign ctl.settle_idx = pick_exit.idx;

  for (genvar i = 0; i < VERTEX_COUNT; i++) begin : g_cell
    dgsp_cell #(
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .is_source (32'(cfg_source_r) == 32'(i)),
      .pick_in   (pick_chain[i]),
      .pick_out  (pick_chain[i+1]),
      .relax_in  (relax_chain[i]),
      .relax_out (relax_chain[i+1]),
      .stat      (stat_vec[i])
    );
    assign settled_vec[i] = stat_vec[i].settled;
  end

  // result assembly
  assign sel_stat    = stat_vec[out_idx_r];
  assign out_load    = (state_r == ST_OUT) && (!out_tvalid_r || out_tready);
  assign out_idx_ext = (VW+2)'(out_idx_r);
  assign dist_ext    = {{OUT_DIST_W{1'b0}}, sel_stat.distance};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      round_r      <= '0;
      col_r        <= '0;
      rd_col_r     <= '0;
      rd_pend_r    <= 1'b0;
      pick_sent_r  <= 1'b0;
      u_known_r    <= 1'b0;
      out_idx_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      rd_pend_r <= ram_re;
      rd_col_r  <= col_r;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == LAST_ADDR) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept && in_tlast) begin
            round_r     <= '0;
            pick_sent_r <= 1'b0;
            state_r     <= ST_PICK;
          end
        end
        ST_PICK: begin
          if (pick_inject) begin
            pick_sent_r <= 1'b1;
          end
          if (pick_exit.valid) begin
            u_known_r <= pick_exit.known;
            col_r     <= '0;
            state_r   <= ST_RELAX;
          end
        end
        ST_RELAX: begin
          col_r <= col_r + 1'b1;
          if (col_r == LAST_V) begin
            if (round_r == LAST_ROUND) begin
              state_r <= ST_DRAIN;
            end else begin
              round_r     <= round_r + 1'b1;
              pick_sent_r <= 1'b0;
              state_r     <= ST_PICK;
            end
          end
        end
        ST_DRAIN: begin
          if (relax_exit.valid && (relax_exit.col == VID_W'(LAST_V))) begin
            out_idx_r <= '0;
            state_r   <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_idx_r <= out_idx_r + 1'b1;
            if (out_idx_r == LAST_V) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if ((state_r == ST_PICK) && pick_exit.valid) begin
      u_r  <= pick_exit.idx;
      du_r <= pick_exit.distance;
    end
    if (out_load) begin
      out_vid_r   <= out_idx_ext[FLD_VID_W-1:0];
      out_dist_r  <= sel_stat.known ? dist_ext[OUT_DIST_W-1:0] : '0;
      out_reach_r <= sel_stat.known;
      out_last_r  <= (out_idx_r == LAST_V);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'b0, out_dist_r, out_vid_r};
  assign out_tuser  = out_reach_r;
  assign out_tlast  = out_last_r;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_source_r <= '0;
    end else if (cfg_wr && (cfg_paddr[2] == CFG_IDX_SOURCE)) begin
      cfg_source_r <= cfg_pwdata[SRC_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_SOURCE) ? {30'b0, cfg_source_r} : '0;

  `DGSP_ASSERT_IMP(a_pick_trails_relax, pick_inject, !relax_chain[0].valid)
  `DGSP_ASSERT_IMP(a_clear_quiet, state_r == ST_CLEAR, !in_tready && !out_tvalid_r)
  `DGSP_ASSERT_IMP(a_settled_count, state_r == ST_OUT,
                   $countones(settled_vec) == VERTEX_COUNT - 1)
  `DGSP_ASSERT_IMP(a_relax_in_run, relax_exit.valid,
                   state_r == ST_PICK || state_r == ST_RELAX || state_r == ST_DRAIN)
  `DGSP_ASSERT_NXT(a_settle_leaves_pick, ctl.settle, state_r == ST_RELAX)

endmodule

`default_nettype wire
